@@ src/mes_pkg.sv @@
// Shared types, constants and the control program of the Mandelbrot escape shader.
// Used by every module of the block; depends on nothing.
package mes_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W = COORD_W - 4;
  localparam int ITER_W = 16;
  localparam int PIX_W = 14;
  localparam int SCALE_W = COORD_W - 1;
  localparam int MUL_W = 2 * COORD_W;
  localparam int MAG_W = 2 * (COORD_W - 1) + 1 - FRAC_W;
  localparam int NORM_W = MAG_W + 1;
  localparam int WIDE_W = PIX_W + SCALE_W + 3;
  localparam int PP_W = PIX_W + SCALE_W;
  localparam int SHADE_FRAC = 16;
  localparam int SHADE_W = SHADE_FRAC + 1;
  localparam int RNG_W = SHADE_W + ITER_W;
  localparam int DCNT_W = $clog2(ITER_W);
  localparam int UPC_W = 4;
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int REG_IDX_W = 3;

  localparam logic [SHADE_W-1:0] ONE_Q16 = SHADE_W'(1) << SHADE_FRAC;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(345032);
  localparam logic signed [COORD_W-1:0] ORIGIN_X_RST = -32'sd487530496;
  localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST = 32'sd268434896;
  localparam logic [NORM_W-1:0] ESCAPE_RST = NORM_W'(1073741824);
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(300);
  localparam logic [1:0] MODE_RST = 2'd0;
  localparam logic [SHADE_W-1:0] RANGE_RST = SHADE_W'(32768);

  localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RANGE = 3'd6;

  localparam logic [1:0] MODE_SMOOTH = 2'd0;
  localparam logic [1:0] MODE_SHARP = 2'd1;
  localparam logic [1:0] MODE_RANGED = 2'd2;

  localparam logic [UPC_W-1:0] UPC_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] UPC_LOOP = 4'd4;
  localparam logic [UPC_W-1:0] UPC_DIV = 4'd11;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_in_row;
  } pixel_t;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [ITER_W-1:0]  iteration_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [SCALE_W-1:0]        scale;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [NORM_W-1:0]         escape_norm_limit;
    logic [ITER_W-1:0]         max_iterations;
    logic [1:0]                output_mode;
    logic [SHADE_W-1:0]        range_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_ZRZI, MUL_ZRZR, MUL_ZIZI, MUL_PXSC, MUL_PYSC, MUL_RNGMAX
  } mul_sel_t;

  typedef enum logic [2:0] {
    TAKE_NONE, TAKE_RI, TAKE_RR, TAKE_II, TAKE_CR, TAKE_CI
  } take_sel_t;

  typedef enum logic [2:0] {
    JMP_NONE, JMP_ALWAYS, JMP_WAIT, JMP_ITER, JMP_DIV
  } jmp_t;

  typedef struct packed {
    logic             load;
    logic             init;
    mul_sel_t         mul;
    take_sel_t        take;
    logic             zupd;
    logic             div_init;
    logic             div_step;
    logic             shade_wr;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic iter_go;
    logic div_go;
  } flags_t;

  function automatic ctl_t ucode(input logic [UPC_W-1:0] upc);
    ctl_t w;
    w = '0;
    case (upc)
      4'd0: begin
        w.load = 1'b1;
        w.jmp = JMP_WAIT;
        w.target = UPC_IDLE;
      end
      4'd1: begin
        w.init = 1'b1;
        w.mul = MUL_PXSC;
      end
      4'd2: begin
        w.take = TAKE_CR;
        w.mul = MUL_PYSC;
      end
      4'd3: begin
        w.take = TAKE_CI;
        w.mul = MUL_ZRZI;
      end
      4'd4: begin
        w.take = TAKE_RI;
      end
      4'd5: begin
        w.zupd = 1'b1;
      end
      4'd6: begin
        w.mul = MUL_ZRZR;
      end
      4'd7: begin
        w.take = TAKE_RR;
        w.mul = MUL_ZIZI;
      end
      4'd8: begin
        w.take = TAKE_II;
      end
      4'd9: begin
        w.mul = MUL_ZRZI;
        w.jmp = JMP_ITER;
        w.target = UPC_LOOP;
      end
      4'd10: begin
        w.mul = MUL_RNGMAX;
        w.div_init = 1'b1;
      end
      4'd11: begin
        w.div_step = 1'b1;
        w.jmp = JMP_DIV;
        w.target = UPC_DIV;
      end
      4'd12: begin
        w.shade_wr = 1'b1;
        w.jmp = JMP_ALWAYS;
        w.target = UPC_IDLE;
      end
      default: begin
        w.jmp = JMP_ALWAYS;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    r = v[COORD_W-1:0];
    if (v[WIDE_W-1] && !(&v[WIDE_W-2:COORD_W-1])) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else if (!v[WIDE_W-1] && (|v[WIDE_W-2:COORD_W-1])) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/mes_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on mes_pkg for the register layout and reset values.
module mes_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mes_pkg::PADDR_W-1:0]   paddr,
  input  logic [mes_pkg::PDATA_W-1:0]   pwdata,
  output logic [mes_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mes_pkg::cfg_t                 cfg
);

  logic [mes_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign idx = paddr[mes_pkg::PADDR_W-1 -: mes_pkg::REG_IDX_W];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= mes_pkg::SCALE_RST;
      cfg.origin_x <= mes_pkg::ORIGIN_X_RST;
      cfg.origin_y <= mes_pkg::ORIGIN_Y_RST;
      cfg.escape_norm_limit <= mes_pkg::ESCAPE_RST;
      cfg.max_iterations <= mes_pkg::MAX_ITER_RST;
      cfg.output_mode <= mes_pkg::MODE_RST;
      cfg.range_limit <= mes_pkg::RANGE_RST;
    end else if (wr) begin
      unique case (idx)
        mes_pkg::REG_SCALE: cfg.scale <= pwdata[mes_pkg::SCALE_W-1:0];
        mes_pkg::REG_ORIGIN_X: cfg.origin_x <= pwdata[mes_pkg::COORD_W-1:0];
        mes_pkg::REG_ORIGIN_Y: cfg.origin_y <= pwdata[mes_pkg::COORD_W-1:0];
        mes_pkg::REG_ESCAPE: cfg.escape_norm_limit <= pwdata[mes_pkg::NORM_W-1:0];
        mes_pkg::REG_MAX_ITER: cfg.max_iterations <= pwdata[mes_pkg::ITER_W-1:0];
        mes_pkg::REG_MODE: cfg.output_mode <= pwdata[1:0];
        mes_pkg::REG_RANGE: cfg.range_limit <= pwdata[mes_pkg::SHADE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mes_pkg::REG_SCALE: prdata = mes_pkg::PDATA_W'(cfg.scale);
      mes_pkg::REG_ORIGIN_X: prdata = mes_pkg::PDATA_W'($signed(cfg.origin_x));
      mes_pkg::REG_ORIGIN_Y: prdata = mes_pkg::PDATA_W'($signed(cfg.origin_y));
      mes_pkg::REG_ESCAPE: prdata = mes_pkg::PDATA_W'(cfg.escape_norm_limit);
      mes_pkg::REG_MAX_ITER: prdata = mes_pkg::PDATA_W'(cfg.max_iterations);
      mes_pkg::REG_MODE: prdata = mes_pkg::PDATA_W'(cfg.output_mode);
      mes_pkg::REG_RANGE: prdata = mes_pkg::PDATA_W'(cfg.range_limit);
      default: prdata = '0;
    endcase
  end

endmodule

@@ src/mes_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mes_pkg for the control word and the program.
module mes_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mes_pkg::flags_t flags,
  output mes_pkg::ctl_t   ctl,
  output logic            busy
);

  logic [mes_pkg::UPC_W-1:0] upc;
  logic [mes_pkg::UPC_W-1:0] upc_next;

  assign ctl = mes_pkg::ucode(upc);
  assign busy = (upc != mes_pkg::UPC_IDLE);

  always_comb begin
    upc_next = upc + mes_pkg::UPC_W'(1);
    unique case (ctl.jmp)
      mes_pkg::JMP_NONE: upc_next = upc + mes_pkg::UPC_W'(1);
      mes_pkg::JMP_ALWAYS: upc_next = ctl.target;
      mes_pkg::JMP_WAIT: if (!start) begin
        upc_next = ctl.target;
      end
      mes_pkg::JMP_ITER: if (flags.iter_go) begin
        upc_next = ctl.target;
      end
      mes_pkg::JMP_DIV: if (flags.div_go) begin
        upc_next = ctl.target;
      end
      default: upc_next = mes_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mes_pkg::UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ src/mes_datapath.sv @@
// Datapath: coordinate mapping, shared multiplier, z update, norm test and shade divider.
// Depends on mes_pkg; driven by the control word from mes_sequencer.
module mes_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mes_pkg::pixel_t  pixel,
  input  mes_pkg::cfg_t    cfg,
  input  mes_pkg::ctl_t    ctl,
  output mes_pkg::flags_t  flags,
  output logic             done,
  output mes_pkg::result_t result
);

  logic [mes_pkg::PIX_W-1:0]          px;
  logic [mes_pkg::PIX_W-1:0]          py;
  logic                               last_q;
  logic signed [mes_pkg::COORD_W-1:0] cr;
  logic signed [mes_pkg::COORD_W-1:0] ci;
  logic signed [mes_pkg::COORD_W-1:0] zr;
  logic signed [mes_pkg::COORD_W-1:0] zi;
  logic [mes_pkg::MAG_W-1:0]          rr;
  logic [mes_pkg::MAG_W-1:0]          ii;
  logic signed [mes_pkg::MAG_W:0]     ri;
  logic [mes_pkg::MUL_W-1:0]          prod;
  logic                               psign;
  logic [mes_pkg::ITER_W-1:0]         count;
  logic [mes_pkg::ITER_W-1:0]         quot;
  logic [mes_pkg::ITER_W-1:0]         rem;
  logic [mes_pkg::DCNT_W-1:0]         dcnt;

  logic [mes_pkg::COORD_W-1:0]        opa;
  logic [mes_pkg::COORD_W-1:0]        opb;
  logic                               osign;
  logic [mes_pkg::MAG_W-1:0]          mag_p;
  logic signed [mes_pkg::MAG_W:0]     conv_s;
  logic signed [mes_pkg::WIDE_W-1:0]  cr_sum;
  logic signed [mes_pkg::WIDE_W-1:0]  ci_sum;
  logic signed [mes_pkg::WIDE_W-1:0]  nr_sum;
  logic signed [mes_pkg::WIDE_W-1:0]  ni_sum;
  logic [mes_pkg::NORM_W-1:0]         norm;
  logic [mes_pkg::ITER_W-1:0]         maxi;
  logic [mes_pkg::ITER_W:0]           rem2;
  logic                               rem_ge;
  logic [mes_pkg::SHADE_W-1:0]        shade_val;

  assign maxi = (cfg.max_iterations == '0) ? mes_pkg::ITER_W'(1) : cfg.max_iterations;

  always_comb begin
    opa = '0;
    opb = '0;
    osign = 1'b0;
    case (ctl.mul)
      mes_pkg::MUL_ZRZI: begin
        opa = mes_pkg::mag(zr);
        opb = mes_pkg::mag(zi);
        osign = zr[mes_pkg::COORD_W-1] ^ zi[mes_pkg::COORD_W-1];
      end
      mes_pkg::MUL_ZRZR: begin
        opa = mes_pkg::mag(zr);
        opb = mes_pkg::mag(zr);
      end
      mes_pkg::MUL_ZIZI: begin
        opa = mes_pkg::mag(zi);
        opb = mes_pkg::mag(zi);
      end
      mes_pkg::MUL_PXSC: begin
        opa = mes_pkg::COORD_W'(px);
        opb = mes_pkg::COORD_W'(cfg.scale);
      end
      mes_pkg::MUL_PYSC: begin
        opa = mes_pkg::COORD_W'(py);
        opb = mes_pkg::COORD_W'(cfg.scale);
      end
      mes_pkg::MUL_RNGMAX: begin
        opa = mes_pkg::COORD_W'(cfg.range_limit);
        opb = mes_pkg::COORD_W'(maxi);
      end
      default: begin
      end
    endcase
  end

  // Products hold magnitudes; the Q4.28 result truncates toward zero before the sign.
  assign mag_p = prod[mes_pkg::FRAC_W +: mes_pkg::MAG_W];
  assign conv_s = psign ? -$signed({1'b0, mag_p}) : $signed({1'b0, mag_p});

  assign cr_sum = mes_pkg::WIDE_W'($signed(cfg.origin_x))
                + $signed(mes_pkg::WIDE_W'(prod[mes_pkg::PP_W-1:0]));
  assign ci_sum = mes_pkg::WIDE_W'($signed(cfg.origin_y))
                - $signed(mes_pkg::WIDE_W'(prod[mes_pkg::PP_W-1:0]));
  assign nr_sum = $signed(mes_pkg::WIDE_W'(rr)) - $signed(mes_pkg::WIDE_W'(ii))
                + mes_pkg::WIDE_W'(cr);
  assign ni_sum = mes_pkg::WIDE_W'(ri) + mes_pkg::WIDE_W'(ri) + mes_pkg::WIDE_W'(ci);

  assign norm = mes_pkg::NORM_W'(rr) + mes_pkg::NORM_W'(ii);
  assign flags.iter_go = (norm < cfg.escape_norm_limit) && (count < maxi);
  assign flags.div_go = (dcnt != mes_pkg::DCNT_W'(mes_pkg::ITER_W - 1));

  assign rem2 = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, maxi});

  always_comb begin
    case (cfg.output_mode)
      mes_pkg::MODE_SMOOTH: shade_val = (count < maxi) ? mes_pkg::SHADE_W'(quot) : '0;
      mes_pkg::MODE_SHARP: shade_val = (count == maxi) ? '0 : mes_pkg::ONE_Q16;
      mes_pkg::MODE_RANGED: begin
        shade_val = ({1'b0, count, mes_pkg::SHADE_FRAC'(0)} < prod[mes_pkg::RNG_W-1:0])
                  ? mes_pkg::ONE_Q16 : '0;
      end
      default: shade_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load && start) begin
      px <= pixel.pixel_x;
      py <= pixel.pixel_y;
      last_q <= pixel.last_in_row;
    end
    if (ctl.init) begin
      zr <= '0;
      zi <= '0;
      rr <= '0;
      ii <= '0;
      count <= '0;
    end
    if (ctl.mul != mes_pkg::MUL_NONE) begin
      prod <= mes_pkg::MUL_W'(opa) * mes_pkg::MUL_W'(opb);
      psign <= osign;
    end
    case (ctl.take)
      mes_pkg::TAKE_RI: ri <= conv_s;
      mes_pkg::TAKE_RR: rr <= mag_p;
      mes_pkg::TAKE_II: ii <= mag_p;
      mes_pkg::TAKE_CR: cr <= mes_pkg::sat_coord(cr_sum);
      mes_pkg::TAKE_CI: ci <= mes_pkg::sat_coord(ci_sum);
      default: begin
      end
    endcase
    if (ctl.zupd) begin
      zr <= mes_pkg::sat_coord(nr_sum);
      zi <= mes_pkg::sat_coord(ni_sum);
      count <= count + mes_pkg::ITER_W'(1);
    end
    if (ctl.div_init) begin
      rem <= count;
      quot <= '0;
      dcnt <= '0;
    end
    if (ctl.div_step) begin
      rem <= rem_ge ? mes_pkg::ITER_W'(rem2 - {1'b0, maxi}) : rem2[mes_pkg::ITER_W-1:0];
      quot <= {quot[mes_pkg::ITER_W-2:0], rem_ge};
      dcnt <= dcnt + mes_pkg::DCNT_W'(1);
    end
    if (ctl.shade_wr) begin
      result.shade <= shade_val;
      result.iteration_count <= count;
      result.last <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.shade_wr;
    end
  end

endmodule

@@ src/mandelbrot_escape_shader_unit.sv @@
// A pixel word taken at a start edge yields its result word once its iterations and the shade
// division finish; done is high for one cycle with it and cannot be stalled.
// Pixels are taken one at a time: a new one is not started while busy. The single shared 32x32
// multiplier serves three products per iteration, and a shade divider follows the iterations.
// Reset (rst, synchronous) returns the sequencer to idle, clears done and loads the
// register defaults; a new pixel can be started in the cycle its predecessor's done is high.
module mandelbrot_escape_shader_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  mes_pkg::pixel_t             pixel,
  output logic                        done,
  output mes_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mes_pkg::PADDR_W-1:0] paddr,
  input  logic [mes_pkg::PDATA_W-1:0] pwdata,
  output logic [mes_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  mes_pkg::cfg_t   cfg;
  mes_pkg::ctl_t   ctl;
  mes_pkg::flags_t flags;

  mes_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mes_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  mes_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .pixel  (pixel),
    .cfg    (cfg),
    .ctl    (ctl),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_shader_unit: directed corner cases, then random row spans.
// It predicts each result word with its own fixed-point escape-time model; it uses mes_pkg and the DUT.
module tb;
  import mes_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int FREE_RUN_CAP = 1000;
  localparam int ROW_PIXEL = 778;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  pixel_t              pixel = '0;
  logic                done;
  result_t             result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  cfg_t        shader_cfg;
  result_t     pending_results[$];
  result_t     oldest_result;
  int          fail_count = 0;
  int          sender_idle_pct = 0;
  int unsigned cycle_count = 0;

  mandelbrot_escape_shader_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // The magnitude of the product is truncated, then the sign is applied.
  function automatic longint fixed_mul(longint a, longint b);
    logic [63:0] ua, ub, prod;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = (ua * ub) >> FRAC_W;
    return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic result_t predict_shader(pixel_t p);
    longint          sc, cr, ci, zr, zi, rr, ii, ri;
    longint unsigned cap, count, norm;
    result_t         r;
    sc = longint'(shader_cfg.scale);
    cr = clamp_coord(longint'($signed(shader_cfg.origin_x)) + longint'(p.pixel_x) * sc);
    ci = clamp_coord(longint'($signed(shader_cfg.origin_y)) - longint'(p.pixel_y) * sc);
    cap = (shader_cfg.max_iterations == 0) ? 1 : longint'(shader_cfg.max_iterations);
    zr = 0;
    zi = 0;
    rr = 0;
    ii = 0;
    count = 0;
    do begin
      ri = fixed_mul(zr, zi);
      zr = clamp_coord(rr - ii + cr);
      zi = clamp_coord(2 * ri + ci);
      count++;
      rr = fixed_mul(zr, zr);
      ii = fixed_mul(zi, zi);
      norm = longint'(rr + ii);
    end while (norm < shader_cfg.escape_norm_limit && count < cap);
    r.iteration_count = count[ITER_W-1:0];
    r.last = p.last_in_row;
    case (shader_cfg.output_mode)
      MODE_SMOOTH: r.shade = (count < cap) ? SHADE_W'((count << SHADE_FRAC) / cap) : '0;
      MODE_SHARP: r.shade = (count == cap) ? '0 : ONE_Q16;
      MODE_RANGED: begin
        r.shade = ((count << SHADE_FRAC) < longint'(shader_cfg.range_limit) * cap) ?
                  ONE_Q16 : '0;
      end
      default: r.shade = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: shade %0d, count %0d, last %0d",
                 $time, result.shade, result.iteration_count, result.last);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.shade !== oldest_result.shade) begin
          $display("%0t: shade mismatch: expected %0d, actual %0d",
                   $time, oldest_result.shade, result.shade);
          fail_count++;
        end
        if (result.iteration_count !== oldest_result.iteration_count) begin
          $display("%0t: iteration_count mismatch: expected %0d, actual %0d",
                   $time, oldest_result.iteration_count, result.iteration_count);
          fail_count++;
        end
        if (result.last !== oldest_result.last) begin
          $display("%0t: last mismatch: expected %0d, actual %0d",
                   $time, oldest_result.last, result.last);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCALE: shader_cfg.scale = value[SCALE_W-1:0];
      REG_ORIGIN_X: shader_cfg.origin_x = value[COORD_W-1:0];
      REG_ORIGIN_Y: shader_cfg.origin_y = value[COORD_W-1:0];
      REG_ESCAPE: shader_cfg.escape_norm_limit = value[NORM_W-1:0];
      REG_MAX_ITER: shader_cfg.max_iterations = value[ITER_W-1:0];
      REG_MODE: shader_cfg.output_mode = value[1:0];
      REG_RANGE: shader_cfg.range_limit = value[SHADE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_view(input logic [SCALE_W-1:0] sc, input logic [COORD_W-1:0] ox,
                              input logic [COORD_W-1:0] oy, input logic [NORM_W-1:0] esc,
                              input logic [ITER_W-1:0] cap, input logic [1:0] mode,
                              input logic [SHADE_W-1:0] rng);
    write_reg(REG_SCALE, PDATA_W'(sc));
    write_reg(REG_ORIGIN_X, PDATA_W'(ox));
    write_reg(REG_ORIGIN_Y, PDATA_W'(oy));
    write_reg(REG_ESCAPE, PDATA_W'(esc));
    write_reg(REG_MAX_ITER, PDATA_W'(cap));
    write_reg(REG_MODE, PDATA_W'(mode));
    write_reg(REG_RANGE, PDATA_W'(rng));
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input logic last_flag);
    pixel_t p;
    int     gap;
    p.pixel_x = x;
    p.pixel_y = y;
    p.last_in_row = last_flag;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 1 << $urandom_range(1, 8));
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_shader(p));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(0, 0, 1'b0);
    send_pixel(1413, ROW_PIXEL, 1'b1);
    send_pixel(16383, 16383, 1'b1);
    send_pixel(16383, 0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_coordinate_extremes();
    program_view(31'h7fffffff, 32'h7fffffff, 32'h80000000, 36'hfffffffff, 3, MODE_SMOOTH, 0);
    send_pixel(16383, 16383, 1'b1);
    send_pixel(0, 0, 1'b0);
    wait_for_results();
    program_view(0, 32'h80000000, 32'h7fffffff, NORM_W'(1 << 30), 5, 2'd3, 17'h1ffff);
    send_pixel(16383, 0, 1'b0);
    send_pixel(0, 16383, 1'b1);
    wait_for_results();
  endtask

  task automatic test_zero_escape_limit();
    program_view(SCALE_RST, ORIGIN_X_RST, ORIGIN_Y_RST, 0, 16'hffff, MODE_SMOOTH, 1);
    send_pixel(1413, ROW_PIXEL, 1'b0);
    wait_for_results();
    write_reg(REG_MODE, PDATA_W'(MODE_RANGED));
    send_pixel(1413, ROW_PIXEL, 1'b1);
    wait_for_results();
  endtask

  task automatic test_zero_iteration_cap();
    program_view(SCALE_RST, ORIGIN_X_RST, ORIGIN_Y_RST, NORM_W'(1 << 30), 0, MODE_SMOOTH,
                 RANGE_RST);
    send_pixel(0, 0, 1'b1);
    wait_for_results();
    write_reg(REG_MODE, PDATA_W'(MODE_SHARP));
    send_pixel(1413, ROW_PIXEL, 1'b0);
    wait_for_results();
  endtask

  task automatic test_shade_modes();
    logic [1:0] mode;
    program_view(SCALE_RST, ORIGIN_X_RST, ORIGIN_Y_RST, NORM_W'(1 << 30), 20, MODE_SMOOTH,
                 RANGE_RST);
    for (int m = 0; m < 4; m++) begin
      mode = 2'(m);
      write_reg(REG_MODE, PDATA_W'(mode));
      send_pixel(1413, ROW_PIXEL, 1'b0);
      send_pixel(0, 0, 1'b1);
      wait_for_results();
    end
    write_reg(REG_MODE, PDATA_W'(MODE_RANGED));
    write_reg(REG_RANGE, PDATA_W'(ONE_Q16));
    send_pixel(1413, ROW_PIXEL, 1'b1);
    wait_for_results();
    write_reg(REG_RANGE, 0);
    send_pixel(0, 0, 1'b0);
    wait_for_results();
    write_reg(REG_RANGE, PDATA_W'(17'h1ffff));
    send_pixel(0, 0, 1'b1);
    wait_for_results();
  endtask

  // A point that escapes exactly when the count reaches the cap still counts as inside.
  task automatic test_escape_on_final_iteration();
    pixel_t  p;
    result_t free_run;
    program_view(SCALE_RST, ORIGIN_X_RST, ORIGIN_Y_RST, NORM_W'(1 << 30), FREE_RUN_CAP,
                 MODE_SMOOTH, RANGE_RST);
    p.pixel_y = ROW_PIXEL;
    p.last_in_row = 1'b1;
    for (int x = 1600; x <= 1800; x++) begin
      p.pixel_x = PIX_W'(x);
      free_run = predict_shader(p);
      if (free_run.iteration_count >= 8 && free_run.iteration_count < FREE_RUN_CAP) break;
    end
    write_reg(REG_MAX_ITER, PDATA_W'(free_run.iteration_count));
    send_pixel(p.pixel_x, p.pixel_y, 1'b1);
    wait_for_results();
    write_reg(REG_MAX_ITER, PDATA_W'(free_run.iteration_count + 1));
    send_pixel(p.pixel_x, p.pixel_y, 1'b0);
    wait_for_results();
  endtask

  // Mostly row spans over a window near the set, with some stray pixels anywhere.
  task automatic test_random_rows(input int idle_pct, input int items);
    logic [SCALE_W-1:0] sc;
    logic [COORD_W-1:0] ox, oy;
    logic [NORM_W-1:0]  esc;
    int                 sent, win, y, x0, len;
    sc = ($urandom_range(0, 7) == 0) ? SCALE_W'($urandom) :
         SCALE_W'($urandom_range(1 << 14, 1 << 21));
    ox = ($urandom_range(0, 7) == 0) ? $urandom :
         COORD_W'(-603979776 + int'($urandom_range(0, 268435456)));
    oy = ($urandom_range(0, 7) == 0) ? $urandom :
         COORD_W'(402653184 - int'($urandom_range(0, 268435456)));
    esc = ($urandom_range(0, 3) == 0) ? {4'($urandom), 32'($urandom)} : NORM_W'(1 << 30);
    program_view(sc, ox, oy, esc, ITER_W'($urandom_range(0, 64)), 2'($urandom_range(0, 3)),
                 SHADE_W'($urandom_range(0, 131071)));
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        win = ($urandom_range(0, 7) == 0) ? 16383 : 1023;
        y = $urandom_range(0, win);
        x0 = $urandom_range(0, win);
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++) begin
          send_pixel(PIX_W'(x0 + k), PIX_W'(y), k == len - 1);
          sent++;
        end
      end
    end
    wait_for_results();
    sender_idle_pct = 0;
  endtask

  initial begin
    shader_cfg.scale = SCALE_RST;
    shader_cfg.origin_x = ORIGIN_X_RST;
    shader_cfg.origin_y = ORIGIN_Y_RST;
    shader_cfg.escape_norm_limit = ESCAPE_RST;
    shader_cfg.max_iterations = MAX_ITER_RST;
    shader_cfg.output_mode = MODE_RST;
    shader_cfg.range_limit = RANGE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_coordinate_extremes();
    test_zero_escape_limit();
    test_zero_iteration_cap();
    test_shade_modes();
    test_escape_on_final_iteration();
    test_random_rows(0, 185);
    test_random_rows(48, 185);
    test_random_rows(23, 185);
    test_random_rows(0, 185);
    test_random_rows(48, 185);
    test_random_rows(23, 185);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mes_pkg.sv
src/mes_cfg_regs.sv
src/mes_sequencer.sv
src/mes_datapath.sv
src/mandelbrot_escape_shader_unit.sv
verif/tb.sv
